### rtl/core/vbyte_posting_list_decoder_core_assert.svh
// Assertion macros shared by the checker of the posting list decoder.
`ifndef VBYTE_POSTING_LIST_DECODER_CORE_ASSERT_SVH
`define VBYTE_POSTING_LIST_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define VBD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vbd: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define VBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vbd: next-cycle check failed");

`endif

### rtl/core/vbd_pkg.sv
`default_nettype none

package vbd_pkg;

    // Varint byte layout
    localparam int unsigned GROUP_W    = 7;
    localparam int unsigned STOP_BIT   = 7;
    localparam int unsigned MAX_GROUPS = 5;
    localparam int unsigned GCNT_W     = 3;

    // Result channel widths
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned M_TDATA_W    = 40;
    localparam int unsigned M_TDATA_PAD  = M_TDATA_W - VALUE_W - 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOCID = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREQ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POS   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               list_done;
        logic               truncated;
        logic               overflow_error;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/vbd_in_stage.sv
`default_nettype none

module vbd_in_stage
    import vbd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  take,
    output logic       valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept a new request when empty or when the held one leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

### rtl/core/vbd_decode.sv
`default_nettype none

module vbd_decode
    import vbd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t item,
    output logic       emit,
    output result_t    result
);

    typedef enum logic [3:0] {
        PH_COUNT = 4'b0001,
        PH_DOCID = 4'b0010,
        PH_FREQ  = 4'b0100,
        PH_POS   = 4'b1000
    } phase_t;

    phase_t              phase_reg,    phase_next;
    logic [VALUE_W-1:0]  accum_reg,    accum_next;
    logic [GCNT_W-1:0]   gcnt_reg,     gcnt_next;
    logic [VALUE_W-1:0]  docs_reg,     docs_next;
    logic [VALUE_W-1:0]  pos_left_reg, pos_left_next;
    logic [VALUE_W-1:0]  docid_reg,    docid_next;
    logic [VALUE_W-1:0]  position_reg, position_next;
    logic                done_reg,     done_next;

    logic [GROUP_W-1:0]  grp;
    logic                stop;
    logic                end_in;
    logic [VALUE_W-1:0]  shifted;
    logic [VALUE_W-1:0]  merged;
    logic                ovf;
    logic                finished;
    logic [VALUE_W-1:0]  num;
    logic [VALUE_W-1:0]  sum_base;
    logic [VALUE_W-1:0]  sum;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic                walk_done;

    assign grp    = item.data_byte[GROUP_W-1:0];
    assign stop   = item.data_byte[STOP_BIT];
    assign end_in = item.region_end;

    // Place the group at its weight; bits above 31 drop off in the last group
    always_comb begin
        case (gcnt_reg)
            3'd0:    shifted = {25'd0, grp};
            3'd1:    shifted = {18'd0, grp, 7'd0};
            3'd2:    shifted = {11'd0, grp, 14'd0};
            3'd3:    shifted = {4'd0, grp, 21'd0};
            3'd4:    shifted = {grp[3:0], 28'd0};
            default: shifted = '0;
        endcase
    end

    assign merged   = accum_reg | shifted;
    assign ovf      = !stop && (gcnt_reg == GCNT_W'(MAX_GROUPS - 1));
    assign finished = stop || ovf;
    assign num      = ovf ? '0 : merged;

    // One adder serves both running sums
    assign sum_base = (phase_reg == PH_DOCID) ? docid_reg : position_reg;
    assign sum      = sum_base + num;

    assign emit = !done_reg && (finished || end_in);

    // Kind code and shown value for the current phase
    always_comb begin
        case (phase_reg)
            PH_COUNT: begin kind = KIND_COUNT; value = num; end
            PH_DOCID: begin kind = KIND_DOCID; value = sum; end
            PH_FREQ:  begin kind = KIND_FREQ;  value = num; end
            PH_POS:   begin kind = KIND_POS;   value = sum; end
            default:  begin kind = KIND_COUNT; value = num; end
        endcase
    end

    // Advance the list walk for one byte
    always_comb begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        gcnt_next     = gcnt_reg;
        docs_next     = docs_reg;
        pos_left_next = pos_left_reg;
        docid_next    = docid_reg;
        position_next = position_reg;
        done_next     = done_reg;

        if (!done_reg) begin
            accum_next = finished ? '0 : merged;
            gcnt_next  = finished ? '0 : gcnt_reg + 3'd1;
            if (finished || end_in) begin
                case (phase_reg)
                    PH_COUNT: begin
                        if (finished) begin
                            if (num == '0) begin
                                done_next = 1'b1;
                            end else begin
                                docs_next  = num;
                                phase_next = PH_DOCID;
                            end
                        end
                    end
                    PH_DOCID: begin
                        docid_next = sum;
                        if (finished) begin
                            phase_next = PH_FREQ;
                        end
                    end
                    PH_FREQ: begin
                        if (finished) begin
                            position_next = '0;
                            if (num == '0) begin
                                docs_next = docs_reg - 32'd1;
                                if (docs_reg == 32'd1) begin
                                    done_next = 1'b1;
                                end else begin
                                    phase_next = PH_DOCID;
                                end
                            end else begin
                                pos_left_next = num;
                                phase_next    = PH_POS;
                            end
                        end
                    end
                    PH_POS: begin
                        position_next = sum;
                        if (finished) begin
                            pos_left_next = pos_left_reg - 32'd1;
                            if (pos_left_reg == 32'd1) begin
                                docs_next = docs_reg - 32'd1;
                                if (docs_reg == 32'd1) begin
                                    done_next = 1'b1;
                                end else begin
                                    phase_next = PH_DOCID;
                                end
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_COUNT;
                    end
                endcase
            end
        end

        // Completion as seen before a region end clears the walk
        walk_done = done_next;

        // Region end returns everything to the start of a list
        if (end_in) begin
            phase_next    = PH_COUNT;
            accum_next    = '0;
            gcnt_next     = '0;
            docs_next     = '0;
            pos_left_next = '0;
            docid_next    = '0;
            position_next = '0;
            done_next     = 1'b0;
        end
    end

    always_comb begin
        result.kind           = kind;
        result.value          = value;
        result.list_done      = walk_done || end_in;
        result.truncated      = end_in && !walk_done;
        result.overflow_error = ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_COUNT;
            accum_reg    <= '0;
            gcnt_reg     <= '0;
            docs_reg     <= '0;
            pos_left_reg <= '0;
            docid_reg    <= '0;
            position_reg <= '0;
            done_reg     <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            gcnt_reg     <= gcnt_next;
            docs_reg     <= docs_next;
            pos_left_reg <= pos_left_next;
            docid_reg    <= docid_next;
            position_reg <= position_next;
            done_reg     <= done_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/vbd_out_stage.sv
`default_nettype none

module vbd_out_stage
    import vbd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t result_in,
    output logic         free,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Slot frees up when empty or when the held request leaves now
    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

### rtl/core/vbyte_posting_list_decoder_core.sv
// Channel  Dir  Bus                         Contents
// s_       in   s_tdata[7:0], s_tlast       data_byte, region_end
// m_       out  m_tdata[39:0], m_tuser[1:0], value, truncated, overflow_error;
//               m_tlast                      kind; list_done
//
// One byte per cycle sustained while results are taken; a byte sits in the input
// register from the edge that accepts it until it is decoded, and any result it
// makes is loaded into the result register by the single decode step between them.
// aresetn clears the valid bits and the list walk to the start of a list.
// A stalled result holds the decode step only when that byte makes a result;
// bytes that make none keep flowing.
`default_nettype none

module vbyte_posting_list_decoder_core
    import vbd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,   // region_end
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] value, [32] truncated,
                                                  // [33] overflow_error, rest zero
    output logic [KIND_W-1:0]          m_tuser,   // [1:0] kind
    output logic                       m_tlast    // list_done
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    emit;
    logic    out_free;
    logic    advance;
    result_t dec_result;
    result_t out_result;

    assign s_item.data_byte  = s_tdata;
    assign s_item.region_end = s_tlast;

    // Decode advances unless its result has nowhere to go
    assign advance = item_valid && (!emit || out_free);

    vbd_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .take    (advance),
        .valid   (item_valid),
        .item    (item)
    );

    vbd_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item),
        .emit    (emit),
        .result  (dec_result)
    );

    vbd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && emit),
        .result_in  (dec_result),
        .free       (out_free),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result_out (out_result)
    );

    // Pack the result request
    assign m_tdata = {{M_TDATA_PAD{1'b0}}, out_result.overflow_error,
                      out_result.truncated, out_result.value};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.list_done;

endmodule

`default_nettype wire

### rtl/core/vbd_checker.sv
`default_nettype none
`include "vbyte_posting_list_decoder_core_assert.svh"

module vbd_checker
    import vbd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]    m_tuser,
    input wire logic                 m_tlast
);

    logic trunc_flag;
    logic ovf_flag;
    logic plain_kind;
    logic value_zero;

    assign trunc_flag = m_tdata[VALUE_W];
    assign ovf_flag   = m_tdata[VALUE_W+1];
    assign plain_kind = (m_tuser == KIND_COUNT) || (m_tuser == KIND_FREQ);
    assign value_zero = (m_tdata[VALUE_W-1:0] == '0);

    // A stalled result request stays up
    `VBD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // A truncated result always ends the list
    `VBD_ASSERT_NOW(a_trunc_last, aclk, aresetn, m_tvalid && trunc_flag, m_tlast)

    // An overlong count or frequency reads as zero
    `VBD_ASSERT_NOW(a_ovf_zero, aclk, aresetn, m_tvalid && ovf_flag && plain_kind, value_zero)

    // Pad bits above the flags stay clear
    `VBD_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:VALUE_W+2] == '0)

endmodule

bind vbyte_posting_list_decoder_core vbd_checker u_vbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### verif/tb_vbyte_posting_list_decoder_core.sv
`default_nettype none

module tb_vbyte_posting_list_decoder_core;
    import vbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 400;

    // Track the list walk and hold the postings still owed by the block
    class posting_list_checker;
        logic [KIND_W-1:0]  phase;
        logic [VALUE_W-1:0] accum;
        logic [5:0]         shift;
        logic [31:0]        docs_left;
        logic [31:0]        pos_left;
        logic [31:0]        docid_sum;
        logic [31:0]        pos_sum;
        bit                 complete;
        result_t            expected_postings[$];
        int                 errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = KIND_COUNT;
            accum     = '0;
            shift     = '0;
            docs_left = '0;
            pos_left  = '0;
            docid_sum = '0;
            pos_sum   = '0;
            complete  = 1'b0;
        endfunction

        function void finish_document();
            docs_left = docs_left - 1;
            if (docs_left == 0) begin
                complete = 1'b1;
            end else begin
                phase = KIND_DOCID;
            end
        endfunction

        // Decode one accepted request and queue the posting it yields, if any
        function void note_request(logic [7:0] data_byte, logic region_end);
            logic [31:0]       grp32;
            logic [31:0]       num;
            logic [KIND_W-1:0] kind;
            bit                num_done;
            bit                ovf;
            result_t           r;
            if (complete) begin
                if (region_end) clear();
                return;
            end
            ovf   = 1'b0;
            grp32 = {25'd0, data_byte[6:0]};
            if (data_byte[STOP_BIT]) begin
                num      = accum | (grp32 << shift);
                num_done = 1'b1;
            end else begin
                accum = accum | (grp32 << shift);
                shift = shift + 6'd7;
                if (shift >= 6'd32) begin
                    num      = '0;
                    ovf      = 1'b1;
                    num_done = 1'b1;
                end else begin
                    num      = accum;
                    num_done = 1'b0;
                end
            end
            if (!num_done && !region_end) return;

            kind = phase;
            case (phase)
                KIND_COUNT: begin
                    r.value = num;
                    if (num_done) begin
                        if (num == 0) begin
                            complete = 1'b1;
                        end else begin
                            docs_left = num;
                            phase     = KIND_DOCID;
                        end
                    end
                end
                KIND_DOCID: begin
                    docid_sum = docid_sum + num;
                    r.value   = docid_sum;
                    if (num_done) phase = KIND_FREQ;
                end
                KIND_FREQ: begin
                    r.value = num;
                    if (num_done) begin
                        pos_sum = '0;
                        if (num == 0) begin
                            finish_document();
                        end else begin
                            pos_left = num;
                            phase    = KIND_POS;
                        end
                    end
                end
                default: begin
                    pos_sum = pos_sum + num;
                    r.value = pos_sum;
                    if (num_done) begin
                        pos_left = pos_left - 1;
                        if (pos_left == 0) finish_document();
                    end
                end
            endcase
            if (num_done) begin
                accum = '0;
                shift = '0;
            end
            r.kind           = kind;
            r.list_done      = complete || region_end;
            r.truncated      = region_end && !complete;
            r.overflow_error = ovf;
            expected_postings.insert(expected_postings.size(), r);
            if (region_end) clear();
        endfunction

        // Compare one accepted posting against the oldest one owed
        function void check_result(result_t got);
            result_t exp;
            if (expected_postings.size() == 0) begin
                $error("unexpected posting: kind %0d value %0h", got.kind, got.value);
                errors++;
                return;
            end
            exp = expected_postings.pop_front();
            if (got.kind !== exp.kind) begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.value !== exp.value) begin
                $error("value: expected %0h, got %0h", exp.value, got.value);
                errors++;
            end
            if (got.list_done !== exp.list_done) begin
                $error("list_done: expected %0b, got %0b", exp.list_done, got.list_done);
                errors++;
            end
            if (got.truncated !== exp.truncated) begin
                $error("truncated: expected %0b, got %0b", exp.truncated, got.truncated);
                errors++;
            end
            if (got.overflow_error !== exp.overflow_error) begin
                $error("overflow_error: expected %0b, got %0b",
                       exp.overflow_error, got.overflow_error);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    int                   rx_idle_pct = 67;
    int                   cycle_count = 0;
    item_t                byte_stream[$];
    posting_list_checker  list_checker = new();

    vbyte_posting_list_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_vbyte_posting_list_decoder_core: errors");
            $finish;
        end
    end

    // Note each accepted request
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) list_checker.note_request(s_tdata, s_tlast);
    end

    // Check accepted postings and stall the result side at random
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind           = m_tuser;
            got.value          = m_tdata[31:0];
            got.list_done      = m_tlast;
            got.truncated      = m_tdata[32];
            got.overflow_error = m_tdata[33];
            list_checker.check_result(got);
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic void push_byte(logic [7:0] b, logic last);
        item_t it;
        it.data_byte  = b;
        it.region_end = last;
        byte_stream.insert(byte_stream.size(), it);
    endfunction

    function automatic logic [31:0] rand_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(15);
        if (r < 85) return $urandom_range(16383);
        return $urandom();
    endfunction

    // Encode one number: minimal, padded with zero groups, or overlong
    function automatic void push_varint(logic [31:0] v);
        logic [6:0] grp [5];
        int         n;
        int         total;
        int         k;
        if ($urandom_range(15) == 0) begin
            for (k = 0; k < 5; k++) push_byte({1'b0, 7'($urandom)}, 1'b0);
            return;
        end
        n = 1;
        for (k = 0; k < 5; k++) begin
            grp[k] = 7'(v >> (7 * k));
            if (k > 0 && (v >> (7 * k)) != 0) n = k + 1;
        end
        total = ($urandom_range(7) == 0) ? int'($urandom_range(5, n)) : n;
        // bits above bit 31 in a fifth group must be dropped
        if (total == 5 && $urandom_range(1) == 1) grp[4][6:4] = 3'($urandom);
        for (k = 0; k < total; k++) push_byte({k == total - 1, grp[k]}, 1'b0);
    endfunction

    // Build one list (documents capped at six, positions at five), then end it cleanly, late or early
    function automatic void build_list();
        int          start;
        int          docs;
        int          npos;
        int          d;
        int          p;
        int          cut;
        int unsigned r;
        logic [31:0] count;
        logic [31:0] freq;
        start = byte_stream.size();
        r = $urandom_range(99);
        count = (r < 5) ? 32'd0 : (r < 90) ? 32'($urandom_range(4, 1)) : rand_value();
        push_varint(count);
        docs = (count > 6) ? 6 : int'(count);
        for (d = 0; d < docs; d++) begin
            push_varint(rand_value());
            freq = ($urandom_range(19) == 0) ? rand_value() : 32'($urandom_range(4));
            push_varint(freq);
            npos = (freq > 5) ? 5 : int'(freq);
            for (p = 0; p < npos; p++) push_varint(rand_value());
        end
        r = $urandom_range(99);
        if (r < 70) begin
            byte_stream[byte_stream.size() - 1].region_end = 1'b1;
        end else if (r < 85) begin
            for (p = $urandom_range(2); p > 0; p--) push_byte(8'($urandom), 1'b0);
            push_byte(8'($urandom), 1'b1);
        end else begin
            cut = $urandom_range(byte_stream.size() - 1, start);
            while (byte_stream.size() > cut + 1) void'(byte_stream.pop_back());
            byte_stream[byte_stream.size() - 1].region_end = 1'b1;
        end
    endfunction

    function automatic void build_phase(int target);
        int k;
        int len;
        while (byte_stream.size() < target) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(8, 1);
                for (k = 0; k < len; k++) push_byte(8'($urandom), k == len - 1);
            end else begin
                build_list();
            end
        end
    endfunction

    // Short lists that hit each corner of the list walk
    function automatic void build_directed();
        int k;
        push_byte(8'h80, 1'b1);                 // zero count, region ends with it
        push_byte(8'h80, 1'b0);                 // zero count ...
        push_byte(8'hFF, 1'b1);                 // ... then an ignored region end
        push_byte(8'h81, 1'b0);                 // one document
        for (k = 0; k < 4; k++) push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b0);                 // fifth group with high bits set
        push_byte(8'h82, 1'b0);                 // two positions
        push_byte(8'h83, 1'b0);
        for (k = 0; k < 5; k++) push_byte(8'h00, 1'b0);  // overlong delta ends list
        push_byte(8'h00, 1'b1);                 // ignored after completion
        push_byte(8'h82, 1'b0);                 // region ends inside a docid
        push_byte(8'h05, 1'b1);
        push_byte(8'h81, 1'b0);                 // region ends on a finished docid
        push_byte(8'h83, 1'b1);
        push_byte(8'h82, 1'b0);                 // zero frequencies end documents
        push_byte(8'h81, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'h80, 1'b1);
        for (k = 0; k < 4; k++) push_byte(8'h7F, 1'b0);
        push_byte(8'h7F, 1'b1);                 // overlong count at region end
        push_byte(8'h00, 1'b1);                 // partial count at region end
    endfunction

    // Send every queued request, idling at random between them
    task automatic drive_stream(int tx_idle_pct);
        item_t it;
        while (byte_stream.size() != 0) begin
            it = byte_stream.pop_front();
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.data_byte;
            s_tlast  <= it.region_end;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        s_tvalid <= 1'b0;
    endtask

    // Let the last request be noted, then wait for every owed posting
    task automatic drain();
        @(posedge aclk);
        while (list_checker.expected_postings.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        build_directed();
        build_phase(PHASE_BYTES);
        drive_stream(10);
        drain();

        // swap the idling
        rx_idle_pct <= 10;
        build_phase(PHASE_BYTES);
        drive_stream(67);
        drain();

        // full rate on both sides
        rx_idle_pct <= 0;
        build_phase(PHASE_BYTES);
        drive_stream(0);
        drain();

        repeat (10) @(posedge aclk);
        if (list_checker.errors == 0 && list_checker.expected_postings.size() == 0) begin
            $display("tb_vbyte_posting_list_decoder_core: clean");
        end else begin
            $display("tb_vbyte_posting_list_decoder_core: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
